/* hw/rtl/crcs_pkg.sv */
// Shared types and constants of the custom RISC step core.
`default_nettype none
package crcs_pkg;

  // Memory geometry
  localparam int MemAddrBits = 20;
  localparam int MemDepth    = 1 << MemAddrBits;

  // Request commands
  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdStart = 2'd2,
    CmdStep  = 2'd3
  } cmd_e;

  // Run state codes
  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StHalt  = 2'd1;
  localparam logic [1:0] StFault = 2'd2;

  // Architectural constants
  localparam logic [31:0] StackTop  = 32'hffff_fffc;
  localparam logic [31:0] EntryAddr = 32'h0001_0000;
  localparam logic [7:0]  TrapVec   = 8'h02;
  localparam logic [7:0]  OutVec    = 8'h04;
  localparam logic [3:0]  SpReg     = 4'd14;
  localparam logic [3:0]  BpReg     = 4'd15;

  // ALU operation codes (low five opcode bits)
  localparam logic [4:0] AluAdd = 5'h01;
  localparam logic [4:0] AluSub = 5'h03;
  localparam logic [4:0] AluMul = 5'h05;
  localparam logic [4:0] AluDiv = 5'h07;
  localparam logic [4:0] AluShr = 5'h09;
  localparam logic [4:0] AluShl = 5'h0b;
  localparam logic [4:0] AluAnd = 5'h0d;
  localparam logic [4:0] AluOr  = 5'h0f;
  localparam logic [4:0] AluXor = 5'h11;
  localparam logic [4:0] AluCmp = 5'h13;

  // Flag bit positions
  localparam int FlagN = 0;
  localparam int FlagZ = 1;
  localparam int FlagC = 2;
  localparam int FlagV = 3;

  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] byte_address;
    logic [7:0]  write_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [7:0]  read_byte;
    logic [31:0] program_counter;
  } out_req_t;

endpackage
`default_nettype wire

/* hw/rtl/custom_risc_cpu_step_core.sv */
// Top level: command sequencer of the step core around byte memory and register file.
// A stalled result holds the sequencer in its last state.
// Throughput: one request at a time; set by the single byte-wide memory port (one byte
//   per cycle), the register file's single read port and the bit-serial divider.
// Reset: registers, ip and flags read as zero, run state running; memory is undefined
//   until written, no clearing pass.
`default_nettype none
module custom_risc_cpu_step_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire crcs_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output crcs_pkg::out_req_t      out_req_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_CMDWR, S_RDONE, S_START, S_START2, S_STEP, S_DECODE,
    S_RA, S_RB, S_RC, S_RD, S_EXEC, S_DIVW, S_ALUWB, S_LDWB,
    S_MRD, S_MWR, S_PUSHRD, S_PUSHSP, S_POPRD, S_POPA, S_POPSP, S_POPWB,
    S_TRAPV, S_SETIP, S_CALL1, S_CALL2, S_CALL3, S_CALL4,
    S_RET1, S_RET2, S_RET3, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    ClsHalt, ClsNop, ClsJump, ClsAluR, ClsAluI, ClsInc, ClsDec, ClsNot,
    ClsMov, ClsPushR, ClsPushI, ClsPop, ClsCall, ClsRet, ClsInt, ClsReti,
    ClsOut, ClsUndef
  } cls_e;

  // Control and architectural state
  state_e             state_q, state_d;
  state_e             ret_q, ret_d;
  state_e             pret_q, pret_d;
  logic [1:0]         run_q, run_d;
  logic [3:0]         flags_q, flags_d;
  logic [31:0]        ip_q, ip_d;
  logic               out_valid_q, out_valid_d;
  crcs_pkg::out_req_t out_q, out_d;

  // Working registers
  cls_e        cls_q, cls_d;
  logic [31:0] w_q, w_d;
  logic [31:0] a_q, a_d;
  logic [31:0] v_q, v_d;
  logic [31:0] data_q, data_d;
  logic [31:0] r1_q, r1_d;
  logic [31:0] r2_q, r2_d;
  logic [31:0] r3_q, r3_d;
  logic [31:0] s2_q, s2_d;
  logic [31:0] res_q, res_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  nb_q, nb_d;
  logic [7:0]  tvec_q, tvec_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic [7:0]  rb_q, rb_d;

  // Unit connections
  logic [crcs_pkg::MemAddrBits-1:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [7:0]  mem_rdata;
  logic [3:0]  rf_raddr;
  logic [31:0] rf_rdata;
  logic        rf_we;
  logic [3:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic        div_start;
  logic        div_busy;
  logic [31:0] div_quot;
  logic [31:0] alu_s2;

  crcs_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  crcs_rf u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata)
  );

  crcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r1_q),
    .divisor_i  (alu_s2),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Instruction fields
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [3:0]  fhi;
  logic [3:0]  flo;
  logic [4:0]  aop;
  logic [31:0] imm16;
  logic [31:0] sext16;
  logic [31:0] imm24;
  logic [2:0]  mov_nb;
  logic [31:0] mov_sized;
  logic [31:0] scaled_addr;
  logic [7:0]  d_b0;
  cls_e        d_cls;
  logic        jmp_take;
  logic [31:0] jmp_off;
  logic [31:0] ip_inc;
  logic [31:0] alu_res;
  logic [63:0] mul_full;
  logic [1:0]  byte_sel;
  logic        acc;

  assign b0     = w_q[31:24];
  assign b1     = w_q[23:16];
  assign fhi    = w_q[23:20];
  assign flo    = w_q[19:16];
  assign aop    = w_q[28:24];
  assign imm16  = {16'd0, w_q[15:0]};
  assign sext16 = {{16{w_q[15]}}, w_q[15:0]};
  assign imm24  = {8'd0, w_q[23:0]};
  assign mov_nb = (b0[7:4] == 4'ha) ? 3'd1 : (b0[7:4] == 4'hb) ? 3'd2 : 3'd4;
  assign mov_sized = (mov_nb == 3'd1) ? {24'd0, r3_q[7:0]} :
                     (mov_nb == 3'd2) ? {16'd0, r3_q[15:0]} : r3_q;
  assign scaled_addr = r1_q + (r2_q << w_q[4:0]);

  assign d_b0    = data_q[31:24];
  assign jmp_off = {{6{data_q[23]}}, data_q[23:0], 2'b00};
  assign ip_inc  = ip_q + 32'd4;

  // Opcode classification at decode
  always_comb begin
    unique case (d_b0)
      8'h00, 8'hfe: d_cls = ClsHalt;
      8'h01:        d_cls = ClsNop;
      8'h11, 8'h13, 8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d: d_cls = ClsJump;
      8'h41, 8'h43, 8'h45, 8'h47, 8'h49,
      8'h4b, 8'h4d, 8'h4f, 8'h51, 8'h53: d_cls = ClsAluR;
      8'h54:        d_cls = ClsInc;
      8'h56:        d_cls = ClsDec;
      8'h58:        d_cls = ClsNot;
      8'h61, 8'h63, 8'h65, 8'h67, 8'h69,
      8'h6b, 8'h6d, 8'h6f, 8'h71, 8'h73: d_cls = ClsAluI;
      8'ha0, 8'ha2, 8'ha4, 8'ha5, 8'ha7, 8'ha9, 8'hab, 8'haf,
      8'hb0, 8'hb2, 8'hb4, 8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbf,
      8'hc0, 8'hc2, 8'hc4, 8'hc5, 8'hc7, 8'hc9, 8'hcb: d_cls = ClsMov;
      8'hd0:        d_cls = ClsPushR;
      8'hd1:        d_cls = ClsPushI;
      8'hd2:        d_cls = ClsPop;
      8'hd3:        d_cls = ClsCall;
      8'hd4:        d_cls = ClsRet;
      8'hd5:        d_cls = ClsInt;
      8'hd6:        d_cls = ClsReti;
      8'he2:        d_cls = ClsOut;
      default:      d_cls = ClsUndef;
    endcase
  end

  // Branch conditions
  always_comb begin
    unique case (d_b0)
      8'h13:   jmp_take = flags_q[crcs_pkg::FlagZ];
      8'h15:   jmp_take = !flags_q[crcs_pkg::FlagZ];
      8'h17:   jmp_take = !flags_q[crcs_pkg::FlagZ] && flags_q[crcs_pkg::FlagC];
      8'h19:   jmp_take = !flags_q[crcs_pkg::FlagC];
      8'h1b:   jmp_take = flags_q[crcs_pkg::FlagC];
      8'h1d:   jmp_take = flags_q[crcs_pkg::FlagZ] || !flags_q[crcs_pkg::FlagC];
      default: jmp_take = 1'b1;
    endcase
  end

  // ALU datapath (divide goes through the divider)
  assign alu_s2   = (cls_q == ClsAluI) ? imm16 : r2_q;
  assign mul_full = r1_q * alu_s2;
  always_comb begin
    unique case (aop)
      crcs_pkg::AluAdd: alu_res = r1_q + alu_s2;
      crcs_pkg::AluSub,
      crcs_pkg::AluCmp: alu_res = r1_q + ~alu_s2 + 32'd1;
      crcs_pkg::AluMul: alu_res = mul_full[31:0];
      crcs_pkg::AluShr: alu_res = (|alu_s2[31:5]) ? 32'd0 : r1_q >> alu_s2[4:0];
      crcs_pkg::AluShl: alu_res = (|alu_s2[31:5]) ? 32'd0 : r1_q << alu_s2[4:0];
      crcs_pkg::AluAnd: alu_res = r1_q & alu_s2;
      crcs_pkg::AluOr:  alu_res = r1_q | alu_s2;
      crcs_pkg::AluXor: alu_res = r1_q ^ alu_s2;
      default:          alu_res = 32'd0;
    endcase
  end

  assign mem_addr  = crcs_pkg::MemAddrBits'(a_q + {29'd0, cnt_q});
  assign byte_sel  = 2'(nb_q - 3'd1 - cnt_q);
  assign mem_wdata = (state_q == S_CMDWR) ? v_q[7:0] : 8'(v_q >> {byte_sel, 3'b000});
  assign acc       = in_valid_i && !in_stall_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pret_d      = pret_q;
    run_d       = run_q;
    flags_d     = flags_q;
    ip_d        = ip_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cls_d       = cls_q;
    w_d         = w_q;
    a_d         = a_q;
    v_d         = v_q;
    data_d      = data_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    r3_d        = r3_q;
    s2_d        = s2_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    nb_d        = nb_q;
    tvec_d      = tvec_q;
    ov_d        = ov_q;
    ob_d        = ob_q;
    rb_d        = rb_q;
    mem_we      = 1'b0;
    rf_raddr    = flo;
    rf_we       = 1'b0;
    rf_waddr    = fhi;
    rf_wdata    = 32'd0;
    div_start   = 1'b0;
    in_stall_o  = state_q != S_IDLE;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          ov_d  = 1'b0;
          ob_d  = 8'd0;
          rb_d  = 8'd0;
          cnt_d = 3'd0;
          a_d   = {12'd0, in_req_i.byte_address};
          v_d   = {24'd0, in_req_i.write_byte};
          unique case (crcs_pkg::cmd_e'(in_req_i.command))
            crcs_pkg::CmdWrite: state_d = S_CMDWR;
            crcs_pkg::CmdRead: begin
              nb_d    = 3'd1;
              ret_d   = S_RDONE;
              state_d = S_MRD;
            end
            crcs_pkg::CmdStart: state_d = S_START;
            crcs_pkg::CmdStep:  state_d = S_STEP;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_CMDWR: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_RDONE: begin
        rb_d    = data_q[7:0];
        state_d = S_DONE;
      end
      S_START: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::SpReg;
        rf_wdata = crcs_pkg::StackTop;
        a_d      = crcs_pkg::EntryAddr;
        nb_d     = 3'd4;
        cnt_d    = 3'd0;
        ret_d    = S_START2;
        state_d  = S_MRD;
      end
      S_START2: begin
        ip_d    = data_q;
        run_d   = crcs_pkg::StRun;
        state_d = S_DONE;
      end
      S_STEP: begin
        if (run_q != crcs_pkg::StRun) begin
          state_d = S_DONE;
        end else if (ip_q[1:0] != 2'b00) begin
          // misaligned ip traps before any fetch
          v_d     = ip_q;
          tvec_d  = crcs_pkg::TrapVec;
          pret_d  = S_TRAPV;
          state_d = S_PUSHRD;
        end else begin
          a_d     = ip_q;
          nb_d    = 3'd4;
          cnt_d   = 3'd0;
          ret_d   = S_DECODE;
          state_d = S_MRD;
        end
      end
      S_DECODE: begin
        w_d   = data_q;
        cls_d = d_cls;
        ip_d  = ip_inc;
        priority case (d_cls)
          ClsHalt: begin
            run_d   = crcs_pkg::StHalt;
            state_d = S_DONE;
          end
          ClsNop: state_d = S_DONE;
          ClsJump: begin
            if (jmp_take) begin
              ip_d = ip_inc + jmp_off;
            end
            state_d = S_DONE;
          end
          ClsInt, ClsUndef: begin
            v_d     = ip_inc;
            tvec_d  = (d_cls == ClsInt) ? data_q[23:16] : crcs_pkg::TrapVec;
            pret_d  = S_TRAPV;
            state_d = S_PUSHRD;
          end
          default: state_d = S_RA;
        endcase
      end
      // Operand reads: lo, then b2 field, then hi
      S_RA: begin
        rf_raddr = flo;
        state_d  = S_RB;
      end
      S_RB: begin
        r1_d     = rf_rdata;
        rf_raddr = (cls_q == ClsAluR) ? w_q[15:12] : w_q[11:8];
        state_d  = S_RC;
      end
      S_RC: begin
        r2_d     = rf_rdata;
        rf_raddr = fhi;
        state_d  = S_RD;
      end
      S_RD: begin
        r3_d    = rf_rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (cls_q)
          ClsAluR, ClsAluI: begin
            s2_d = alu_s2;
            if (aop == crcs_pkg::AluDiv) begin
              div_start = 1'b1;
              state_d   = S_DIVW;
            end else begin
              res_d   = alu_res;
              state_d = S_ALUWB;
            end
          end
          ClsInc: begin
            rf_we    = 1'b1;
            rf_wdata = r3_q + 32'd1;
          end
          ClsDec: begin
            rf_we    = 1'b1;
            rf_wdata = r3_q - 32'd1;
          end
          ClsNot: begin
            rf_we    = 1'b1;
            rf_wdata = ~r1_q;
          end
          ClsMov: begin
            nb_d  = mov_nb;
            cnt_d = 3'd0;
            ret_d = S_LDWB;
            unique case (b0[3:0])
              4'h0: begin
                rf_we    = 1'b1;
                rf_waddr = flo;
                rf_wdata = mov_sized;
              end
              4'h2: begin
                a_d     = r1_q;
                state_d = S_MRD;
              end
              4'h4: begin
                a_d     = r3_q;
                v_d     = r1_q;
                ret_d   = S_DONE;
                state_d = S_MWR;
              end
              4'h5: begin
                a_d     = r1_q + sext16;
                state_d = S_MRD;
              end
              4'h7: begin
                a_d     = r1_q + sext16;
                v_d     = r3_q;
                ret_d   = S_DONE;
                state_d = S_MWR;
              end
              4'h9: begin
                a_d     = scaled_addr;
                state_d = S_MRD;
              end
              4'hb: begin
                a_d     = scaled_addr;
                v_d     = r3_q;
                ret_d   = S_DONE;
                state_d = S_MWR;
              end
              default: begin
                // immediate load
                rf_we    = 1'b1;
                rf_wdata = (mov_nb == 3'd1) ? {24'd0, w_q[7:0]} : imm16;
              end
            endcase
          end
          ClsPushR: begin
            v_d     = r1_q;
            pret_d  = S_DONE;
            state_d = S_PUSHRD;
          end
          ClsPushI: begin
            v_d     = imm24;
            pret_d  = S_DONE;
            state_d = S_PUSHRD;
          end
          ClsPop: begin
            pret_d  = S_POPWB;
            state_d = S_POPRD;
          end
          ClsCall: begin
            rf_raddr = crcs_pkg::BpReg;
            state_d  = S_CALL1;
          end
          ClsRet: begin
            pret_d  = S_RET1;
            state_d = S_POPRD;
          end
          ClsReti: begin
            pret_d  = S_SETIP;
            state_d = S_POPRD;
          end
          ClsOut: begin
            if (b1 == 8'd0) begin
              ov_d = 1'b1;
              ob_d = r2_q[7:0];
            end else begin
              v_d     = ip_q;
              tvec_d  = crcs_pkg::OutVec;
              pret_d  = S_TRAPV;
              state_d = S_PUSHRD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DIVW: begin
        if (!div_busy) begin
          res_d   = div_quot;
          state_d = S_ALUWB;
        end
      end
      S_ALUWB: begin
        if (aop == crcs_pkg::AluAdd) begin
          flags_d[crcs_pkg::FlagC] = res_q < r1_q;
        end else if (aop == crcs_pkg::AluSub || aop == crcs_pkg::AluCmp) begin
          flags_d[crcs_pkg::FlagC] = res_q <= r1_q;
        end
        flags_d[crcs_pkg::FlagZ] = res_q == 32'd0;
        flags_d[crcs_pkg::FlagN] = res_q[31];
        // overflow rule uses the destination's old sign
        flags_d[crcs_pkg::FlagV] = (r3_q[31] != res_q[31]) && (r3_q[31] != s2_q[31]);
        rf_we    = aop != crcs_pkg::AluCmp;
        rf_wdata = res_q;
        state_d  = S_DONE;
      end
      S_LDWB: begin
        rf_we    = 1'b1;
        rf_wdata = data_q;
        state_d  = S_DONE;
      end
      // Big-endian multi-byte read, one byte issued per cycle
      S_MRD: begin
        data_d = (cnt_q == 3'd0) ? 32'd0 : {data_q[23:0], mem_rdata};
        if (cnt_q == nb_q) begin
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      // Big-endian multi-byte write
      S_MWR: begin
        mem_we = 1'b1;
        if (cnt_q == nb_q - 3'd1) begin
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_PUSHRD: begin
        rf_raddr = crcs_pkg::SpReg;
        state_d  = S_PUSHSP;
      end
      S_PUSHSP: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::SpReg;
        rf_wdata = rf_rdata - 32'd4;
        a_d      = rf_rdata - 32'd4;
        nb_d     = 3'd4;
        cnt_d    = 3'd0;
        ret_d    = pret_q;
        state_d  = S_MWR;
      end
      S_POPRD: begin
        rf_raddr = crcs_pkg::SpReg;
        state_d  = S_POPA;
      end
      S_POPA: begin
        if (cls_q == ClsPop && rf_rdata >= crcs_pkg::StackTop) begin
          run_d   = crcs_pkg::StFault;
          state_d = S_DONE;
        end else begin
          a_d     = rf_rdata;
          nb_d    = 3'd4;
          cnt_d   = 3'd0;
          ret_d   = S_POPSP;
          state_d = S_MRD;
        end
      end
      S_POPSP: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::SpReg;
        rf_wdata = a_q + 32'd4;
        state_d  = pret_q;
      end
      S_POPWB: begin
        rf_we    = 1'b1;
        rf_waddr = flo;
        rf_wdata = data_q;
        state_d  = S_DONE;
      end
      S_TRAPV: begin
        a_d     = {22'd0, tvec_q, 2'b00};
        nb_d    = 3'd4;
        cnt_d   = 3'd0;
        ret_d   = S_SETIP;
        state_d = S_MRD;
      end
      S_SETIP: begin
        ip_d    = data_q;
        state_d = S_DONE;
      end
      // Call: push bp, push ip, bp = sp, jump
      S_CALL1: begin
        v_d     = rf_rdata;
        pret_d  = S_CALL2;
        state_d = S_PUSHRD;
      end
      S_CALL2: begin
        v_d     = ip_q;
        pret_d  = S_CALL3;
        state_d = S_PUSHRD;
      end
      S_CALL3: begin
        rf_raddr = crcs_pkg::SpReg;
        state_d  = S_CALL4;
      end
      S_CALL4: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::BpReg;
        rf_wdata = rf_rdata;
        ip_d     = {w_q[23:0], 8'd0};
        state_d  = S_DONE;
      end
      // Return: pop ip, pop bp, release frame
      S_RET1: begin
        ip_d    = data_q;
        pret_d  = S_RET2;
        state_d = S_POPRD;
      end
      S_RET2: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::BpReg;
        rf_wdata = data_q;
        rf_raddr = crcs_pkg::SpReg;
        state_d  = S_RET3;
      end
      S_RET3: begin
        rf_we    = 1'b1;
        rf_waddr = crcs_pkg::SpReg;
        rf_wdata = rf_rdata + imm24;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.status          = run_d;
          out_d.out_valid       = ov_q;
          out_d.out_byte        = ob_q;
          out_d.read_byte       = rb_q;
          out_d.program_counter = ip_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_DONE;
      pret_q      <= S_DONE;
      run_q       <= crcs_pkg::StRun;
      flags_q     <= '0;
      ip_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pret_q      <= pret_d;
      run_q       <= run_d;
      flags_q     <= flags_d;
      ip_q        <= ip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    cls_q  <= cls_d;
    w_q    <= w_d;
    a_q    <= a_d;
    v_q    <= v_d;
    data_q <= data_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    r3_q   <= r3_d;
    s2_q   <= s2_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
    nb_q   <= nb_d;
    tvec_q <= tvec_d;
    ov_q   <= ov_d;
    ob_q   <= ob_d;
    rb_q   <= rb_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
`default_nettype wire

/* hw/rtl/crcs_mem.sv */
// Byte-wide main memory, one port, registered read data.
`default_nettype none
module crcs_mem (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [crcs_pkg::MemAddrBits-1:0] addr_i,
  input  wire logic [7:0]                       wdata_i,
  output logic      [7:0]                       rdata_o
);

  logic [7:0] mem_q [crcs_pkg::MemDepth];
  logic [7:0] rdata_q;

  // Write and read at the same address; the read data arrives in the next cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/crcs_rf.sv */
// Register file: 16 x 32 memory with per-entry valid bits (reads zero until written).
`default_nettype none
module crcs_rf (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  raddr_i,
  output logic      [31:0] rdata_o,
  input  wire logic        we_i,
  input  wire logic [3:0]  waddr_i,
  input  wire logic [31:0] wdata_i
);

  logic [31:0] mem_q [16];
  logic [15:0] valid_q;
  logic [31:0] rd_q;
  logic        rd_valid_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // Valid bits stand in for the zero reset of the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : 32'd0;

endmodule
`default_nettype wire

/* hw/rtl/crcs_div.sv */
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module crcs_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic      [31:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quot_q, quot_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic        fits;

  // Restoring step; a zero divisor always fits and yields all ones
  always_comb begin
    trial  = {rem_q, quot_q[31]};
    fits   = trial >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = 6'd32;
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d  = cnt_q - 6'd1;
      rem_d  = fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quot_d = {quot_q[30:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = cnt_q != 6'd0;
  assign quot_o = quot_q;

endmodule
`default_nettype wire
